/* rtl/ldf_pkg.sv */
// ----------------------------------------------------------------------------
// ldf_pkg: shared constants and types of the lossy dielectric field update
// Field widths, pipeline depths, saturation limits and the beats exchanged
// between the multiply front end, the divider and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ldf_pkg;

  // field widths
  localparam int CELL_W = 10;
  localparam int DATA_W = 32;
  localparam int COEF_W = 24;
  localparam int FRAC_W = 16;
  localparam int HIST_W = 48;

  localparam int NUM_CELLS_DEF = 1024;

  // datapath widths
  localparam int A_W     = COEF_W + 2;            // eps - eta or -2*eta
  localparam int C_W     = DATA_W + 1 + FRAC_W;   // additive term, signed Q33.16
  localparam int D_W     = COEF_W + 1;            // divisor eps + eta
  localparam int N_W     = A_W + HIST_W;          // numerator
  localparam int SPLIT_W = HIST_W / 2;            // history split for partial products
  localparam int Q_W     = DATA_W;                // quotient bits worked out

  // pipeline shape
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_STAGES    = Q_W / DIV_STEP_BITS;
  localparam int MUL_LAT       = 3;
  localparam int DIV_LAT       = DIV_STAGES + 3;
  localparam int SB_DEPTH      = 1 + MUL_LAT + DIV_LAT;

  // saturation limits
  localparam logic [DATA_W-1:0] E_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] E_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

  typedef struct packed {
    logic [A_W-1:0]    a;      // coefficient, two's complement
    logic [HIST_W-1:0] b;      // history value, two's complement
    logic              clip;   // clip history to the field range first
    logic [C_W-1:0]    c;      // additive term, two's complement
    logic [D_W-1:0]    d;      // divisor
  } mul_req_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [D_W-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] e;
    logic              flag;
  } div_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] e_field;
    logic [CELL_W-1:0] out_cell_index;
    logic              saturated;
  } result_t;

endpackage

`default_nettype wire

/* rtl/ldf_if.sv */
// ----------------------------------------------------------------------------
// ldf_if: channel interfaces of the lossy dielectric field update
// Valid/ready channels for the configuration write, the cell items and the
// result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ldf_cfg_if;
  logic valid;
  logic ready;
  logic variant;

  modport source (output valid, output variant, input ready);
  modport sink (input valid, input variant, output ready);
endinterface

interface ldf_item_if;
  import ldf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CELL_W-1:0]        cell_index;
  logic signed [DATA_W-1:0] d_now;
  logic signed [DATA_W-1:0] d_before;
  logic [COEF_W-1:0]        permittivity;
  logic [COEF_W-1:0]        loss_term;

  modport source (output valid, output cell_index, output d_now, output d_before,
                  output permittivity, output loss_term, input ready);
  modport sink (input valid, input cell_index, input d_now, input d_before,
                input permittivity, input loss_term, output ready);
endinterface

interface ldf_result_if;
  import ldf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] e_field;
  logic [CELL_W-1:0]        out_cell_index;
  logic                     saturated;

  modport source (output valid, output e_field, output out_cell_index,
                  output saturated, input ready);
  modport sink (input valid, input e_field, input out_cell_index,
                input saturated, output ready);
endinterface

`default_nettype wire

/* rtl/lossy_dielectric_field_update.sv */
// ----------------------------------------------------------------------------
// lossy_dielectric_field_update: per-cell E from D update in a lossy medium
// Reads the cell history, forms the numerator, divides by eps + eta, saturates
// and writes the new history back; results leave through a two-beat buffer.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the output buffer has room and the
//   clearing sweep is over; an item whose cell is still among the 16 in
//   flight waits until it retires
// reset: variant clears to 0, then a sweep zeroes the history memory while
//   items are held off; configuration is taken throughout
`default_nettype none

module lossy_dielectric_field_update #(
  parameter int NUM_CELLS = ldf_pkg::NUM_CELLS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ldf_cfg_if.sink      cfg,
  ldf_item_if.sink     item,
  ldf_result_if.source result
);
  import ldf_pkg::*;

  localparam int ADDR_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  logic variant;

  // pipeline control
  logic [1:0] cnt;
  logic       en;
  logic       hazard;
  logic       busy;
  logic       accept;
  logic       push;
  logic       pop;
  logic       wr_en;

  // sideband line, index 0 is the stage holding the history read data
  logic              sb_valid  [SB_DEPTH];
  logic [CELL_W-1:0] sb_cell   [SB_DEPTH];
  logic              sb_inside [SB_DEPTH];
  logic [HIST_W-1:0] hist_line [SB_DEPTH-1];

  logic [A_W-1:0] s_a;
  logic [C_W-1:0] s_c;
  logic [D_W-1:0] s_d;

  logic [A_W-1:0]           a_in;
  logic [C_W-1:0]           c_in;
  logic [D_W-1:0]           d_in;
  logic [DATA_W:0]          d_diff;
  logic [CELL_W+ADDR_W-1:0] in_ext;
  logic [CELL_W+ADDR_W-1:0] w_ext;
  logic                     in_inside;

  logic [HIST_W-1:0] rd_data;
  logic [HIST_W-1:0] hist0;
  mul_req_t          mreq;
  div_req_t          dreq;
  div_res_t          dres;

  // write-back stage
  logic              w_valid;
  logic [CELL_W-1:0] w_cell;
  logic              w_inside;
  logic [HIST_W-1:0] w_hist;
  result_t           w_beat;
  logic [HIST_W:0]   h_sum;
  logic [HIST_W-1:0] h_next;
  logic              h_clip;

  // output buffer
  result_t r0;
  result_t r1;

  // configuration register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant <= 1'b0;
    end else if (cfg.valid) begin
      variant <= cfg.variant;
    end
  end

  // pipeline advances while the output buffer has room
  assign en     = (cnt != 2'd2);
  assign accept = item.valid & item.ready;
  assign push   = en & w_valid;
  assign pop    = result.valid & result.ready;
  assign wr_en  = push & w_inside;

  // interlock: hold an item whose cell is still in flight
  always_comb begin
    hazard = w_valid && (w_cell == item.cell_index);
    for (int i = 0; i < SB_DEPTH; i++) begin
      if (sb_valid[i] && (sb_cell[i] == item.cell_index)) begin
        hazard = 1'b1;
      end
    end
  end

  assign item.ready = en & ~busy & ~hazard;

  // cell address and range
  assign in_ext    = {{ADDR_W{1'b0}}, item.cell_index};
  assign w_ext     = {{ADDR_W{1'b0}}, w_cell};
  assign in_inside = (32'(item.cell_index) < 32'(NUM_CELLS));

  // operand set-up for the selected form
  always_comb begin
    d_diff = {item.d_now[DATA_W-1], item.d_now} - {item.d_before[DATA_W-1], item.d_before};
    d_in   = {1'b0, item.permittivity} + {1'b0, item.loss_term};
    if (variant) begin
      a_in = A_W'(0) - {1'b0, item.loss_term, 1'b0};
      c_in = {item.d_now[DATA_W-1], item.d_now, FRAC_W'(0)};
    end else begin
      a_in = {2'b00, item.permittivity} - {2'b00, item.loss_term};
      c_in = {d_diff, FRAC_W'(0)};
    end
  end

  ldf_hist_mem #(
    .NUM_CELLS (NUM_CELLS),
    .ADDR_W    (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (en),
    .rd_addr (in_ext[ADDR_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (w_ext[ADDR_W-1:0]),
    .wr_data (w_hist),
    .busy    (busy)
  );

  // sideband valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SB_DEPTH; i++) begin
        sb_valid[i] <= 1'b0;
      end
      w_valid <= 1'b0;
    end else if (en) begin
      sb_valid[0] <= accept;
      for (int i = 1; i < SB_DEPTH; i++) begin
        sb_valid[i] <= sb_valid[i-1];
      end
      w_valid <= sb_valid[SB_DEPTH-1];
    end
  end

  assign hist0 = sb_inside[0] ? rd_data : '0;

  // sideband payload line
  always_ff @(posedge clk) begin
    if (en) begin
      sb_cell[0]   <= item.cell_index;
      sb_inside[0] <= in_inside;
      s_a          <= a_in;
      s_c          <= c_in;
      s_d          <= d_in;
      hist_line[0] <= hist0;
      for (int i = 1; i < SB_DEPTH; i++) begin
        sb_cell[i]   <= sb_cell[i-1];
        sb_inside[i] <= sb_inside[i-1];
      end
      for (int i = 1; i < SB_DEPTH - 1; i++) begin
        hist_line[i] <= hist_line[i-1];
      end
    end
  end

  assign mreq = '{a: s_a, b: hist0, clip: ~variant, c: s_c, d: s_d};

  ldf_mul u_mul (
    .clk  (clk),
    .en   (en),
    .req  (mreq),
    .prod (dreq)
  );

  ldf_div u_div (
    .clk (clk),
    .en  (en),
    .req (dreq),
    .res (dres)
  );

  // history update: replace, or accumulate with 48-bit clip
  always_comb begin
    h_sum  = {hist_line[SB_DEPTH-2][HIST_W-1], hist_line[SB_DEPTH-2]}
           + {{(HIST_W+1-DATA_W){dres.e[DATA_W-1]}}, dres.e};
    h_clip = 1'b0;
    if (variant) begin
      if (h_sum[HIST_W] != h_sum[HIST_W-1]) begin
        h_clip = sb_inside[SB_DEPTH-1];
        h_next = h_sum[HIST_W] ? HIST_MIN : HIST_MAX;
      end else begin
        h_next = h_sum[HIST_W-1:0];
      end
    end else begin
      h_next = {{(HIST_W-DATA_W){dres.e[DATA_W-1]}}, dres.e};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_cell                <= sb_cell[SB_DEPTH-1];
      w_inside              <= sb_inside[SB_DEPTH-1];
      w_hist                <= h_next;
      w_beat.e_field        <= dres.e;
      w_beat.out_cell_index <= sb_cell[SB_DEPTH-1];
      w_beat.saturated      <= dres.flag | h_clip;
    end
  end

  // two-beat output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push && !pop) begin
      cnt <= cnt + 2'd1;
    end else if (pop && !push) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (cnt == 2'd2)) begin
      r0 <= r1;
    end else if (push && ((cnt == 2'd0) || ((cnt == 2'd1) && pop))) begin
      r0 <= w_beat;
    end
    if (push && (cnt == 2'd1) && !pop) begin
      r1 <= w_beat;
    end
  end

  assign result.valid          = (cnt != 2'd0);
  assign result.e_field        = r0.e_field;
  assign result.out_cell_index = r0.out_cell_index;
  assign result.saturated      = r0.saturated;

  // write-back never lands on the cell whose history was just read
  a_wb_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && sb_valid[0]) |-> (sb_cell[0] != w_cell))
    else $error("write-back overlaps a read of the same cell");

  // a stalled pipeline keeps its last stage
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(w_valid))
    else $error("write-back stage moved during stall");

  // buffer, write-back stage and first sideband stage are empty when the clearing sweep ends
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ((cnt == 2'd0) && !w_valid && !sb_valid[0]))
    else $error("items in flight during clearing sweep");

endmodule

`default_nettype wire

/* rtl/ldf_hist_mem.sv */
// ----------------------------------------------------------------------------
// ldf_hist_mem: per-cell field history memory
// One write port and one registered read port; after reset a sweep writes
// zero to every entry, one per cycle, and busy stays high meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_hist_mem #(
  parameter int NUM_CELLS = ldf_pkg::NUM_CELLS_DEF,
  parameter int ADDR_W    = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [ldf_pkg::HIST_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [ldf_pkg::HIST_W-1:0] wr_data,
  output logic                      busy
);
  import ldf_pkg::*;

  logic [HIST_W-1:0] mem [NUM_CELLS];
  logic [ADDR_W-1:0] clr_addr;

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == ADDR_W'(NUM_CELLS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // storage: sweep has the write port while busy
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // no write-back may compete with the clearing sweep
  a_no_write_while_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("history write-back during clearing sweep");

endmodule

`default_nettype wire

/* rtl/ldf_mul.sv */
// ----------------------------------------------------------------------------
// ldf_mul: numerator front end
// Three stages: optional clip of the history, two partial products of the
// coefficient with the history halves, then shift-add with the additive term.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_mul (
  input  logic              clk,
  input  logic              en,
  input  ldf_pkg::mul_req_t req,
  output ldf_pkg::div_req_t prod
);
  import ldf_pkg::*;

  localparam int PL_W = A_W + SPLIT_W + 1;
  localparam int PH_W = A_W + HIST_W - SPLIT_W;

  logic [HIST_W-1:0]       b_clip;
  logic [A_W-1:0]          a1;
  logic [HIST_W-1:0]       b1;
  logic [C_W-1:0]          c1;
  logic [C_W-1:0]          c2;
  logic [D_W-1:0]          d1;
  logic [D_W-1:0]          d2;
  logic signed [SPLIT_W:0] b_lo;
  logic signed [PL_W-1:0]  p_lo;
  logic signed [PH_W-1:0]  p_hi;

  // clip history to the 32-bit field range when asked
  always_comb begin
    b_clip = req.b;
    if (req.clip) begin
      if (!req.b[HIST_W-1] && (|req.b[HIST_W-2:DATA_W-1])) begin
        b_clip = {{(HIST_W-DATA_W){1'b0}}, E_MAX};
      end else if (req.b[HIST_W-1] && !(&req.b[HIST_W-2:DATA_W-1])) begin
        b_clip = {{(HIST_W-DATA_W){1'b1}}, E_MIN};
      end
    end
  end

  assign b_lo = $signed({1'b0, b1[SPLIT_W-1:0]});

  // stage 1: operands
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= req.a;
      b1 <= b_clip;
      c1 <= req.c;
      d1 <= req.d;
    end
  end

  // stage 2: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_lo <= $signed(a1) * b_lo;
      p_hi <= $signed(a1) * $signed(b1[HIST_W-1:SPLIT_W]);
      c2   <= c1;
      d2   <= d1;
    end
  end

  // stage 3: recombine and add
  always_ff @(posedge clk) begin
    if (en) begin
      prod.n <= {p_hi, SPLIT_W'(0)}
              + {{(N_W-PL_W){p_lo[PL_W-1]}}, p_lo}
              + {{(N_W-C_W){c2[C_W-1]}}, c2};
      prod.d <= d2;
    end
  end

endmodule

`default_nettype wire

/* rtl/ldf_div.sv */
// ----------------------------------------------------------------------------
// ldf_div: pipelined signed divider with saturation
// Takes the magnitude, screens quotients too large for the field, then works
// out the quotient bits four per stage, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ldf_div (
  input  logic              clk,
  input  logic              en,
  input  ldf_pkg::div_req_t req,
  output ldf_pkg::div_res_t res
);
  import ldf_pkg::*;

  localparam int HI_W = N_W - Q_W;

  logic [N_W-1:0] mag0;
  logic           neg0;
  logic [D_W-1:0] d0;
  logic           dz0;
  logic           nz0;

  logic [D_W-1:0] st_rem [DIV_STAGES+1];
  logic [Q_W-1:0] st_low [DIV_STAGES+1];
  logic [Q_W-1:0] st_q   [DIV_STAGES+1];
  logic [D_W-1:0] st_d   [DIV_STAGES+1];
  logic           st_neg [DIV_STAGES+1];
  logic           st_dz  [DIV_STAGES+1];
  logic           st_nz  [DIV_STAGES+1];
  logic           st_ovf [DIV_STAGES+1];

  logic [Q_W-1:0]    q_fin;
  logic [DATA_W-1:0] e_next;
  logic              flag_next;

  // magnitude and sign
  always_ff @(posedge clk) begin
    if (en) begin
      neg0 <= req.n[N_W-1];
      mag0 <= req.n[N_W-1] ? (~req.n + 1'b1) : req.n;
      d0   <= req.d;
      dz0  <= (req.d == '0);
      nz0  <= (|req.n);
    end
  end

  // overflow screen: quotient reaches 2^32 when the upper part is not below d
  always_ff @(posedge clk) begin
    if (en) begin
      st_ovf[0] <= (mag0[N_W-1:Q_W] >= HI_W'(d0));
      st_rem[0] <= mag0[Q_W+D_W-1:Q_W];
      st_low[0] <= mag0[Q_W-1:0];
      st_q[0]   <= '0;
      st_d[0]   <= d0;
      st_neg[0] <= neg0;
      st_dz[0]  <= dz0;
      st_nz[0]  <= nz0;
    end
  end

  // restoring steps, DIV_STEP_BITS per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
    logic [D_W-1:0] rem_v [DIV_STEP_BITS+1];
    logic [Q_W-1:0] low_v [DIV_STEP_BITS+1];
    logic [Q_W-1:0] q_v   [DIV_STEP_BITS+1];
    logic [D_W:0]   trial [DIV_STEP_BITS];

    always_comb begin
      rem_v[0] = st_rem[g];
      low_v[0] = st_low[g];
      q_v[0]   = st_q[g];
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
        trial[k]   = {rem_v[k], low_v[k][Q_W-1]};
        low_v[k+1] = {low_v[k][Q_W-2:0], 1'b0};
        if (trial[k] >= {1'b0, st_d[g]}) begin
          rem_v[k+1] = D_W'(trial[k] - {1'b0, st_d[g]});
          q_v[k+1]   = {q_v[k][Q_W-2:0], 1'b1};
        end else begin
          rem_v[k+1] = trial[k][D_W-1:0];
          q_v[k+1]   = {q_v[k][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_rem[g+1] <= rem_v[DIV_STEP_BITS];
        st_low[g+1] <= low_v[DIV_STEP_BITS];
        st_q[g+1]   <= q_v[DIV_STEP_BITS];
        st_d[g+1]   <= st_d[g];
        st_neg[g+1] <= st_neg[g];
        st_dz[g+1]  <= st_dz[g];
        st_nz[g+1]  <= st_nz[g];
        st_ovf[g+1] <= st_ovf[g];
      end
    end
  end

  assign q_fin = st_q[DIV_STAGES];

  // sign, zero divisor and saturation
  always_comb begin
    e_next    = q_fin;
    flag_next = 1'b0;
    priority if (st_dz[DIV_STAGES]) begin
      flag_next = 1'b1;
      if (!st_nz[DIV_STAGES]) begin
        e_next = '0;
      end else begin
        e_next = st_neg[DIV_STAGES] ? E_MIN : E_MAX;
      end
    end else if (st_ovf[DIV_STAGES]) begin
      flag_next = 1'b1;
      e_next    = st_neg[DIV_STAGES] ? E_MIN : E_MAX;
    end else if (st_neg[DIV_STAGES] && (q_fin > E_MIN)) begin
      flag_next = 1'b1;
      e_next    = E_MIN;
    end else if (st_neg[DIV_STAGES]) begin
      e_next = Q_W'(0) - q_fin;
    end else if (q_fin[Q_W-1]) begin
      flag_next = 1'b1;
      e_next    = E_MAX;
    end else begin
      e_next = q_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.e    <= e_next;
      res.flag <= flag_next;
    end
  end

endmodule

`default_nettype wire
